### hw/rtl/evad_pkg.sv
// Shared types, widths, register codes and reset values for the energy VAD endpointer.
// No dependencies; every other file refers to it by scoped names.
`default_nettype none

package evad_pkg;

    localparam int MAX_FRAME_DEF = 1024;

    localparam int SAMPLE_W   = 16;
    localparam int SQ_W       = 31;   // square of a 16-bit sample, at most 2**30
    localparam int LEN_W      = 11;
    localparam int THR_W      = 30;
    localparam int SIL_W      = 8;
    localparam int CNT_W      = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 30;
    localparam int CAUSE_W    = 2;

    localparam logic [LEN_W-1:0] FRAME_LEN_RST      = LEN_W'(160);
    localparam logic [THR_W-1:0] ENERGY_THR_RST     = THR_W'(100000);
    localparam logic [SIL_W-1:0] SILENCE_FRAMES_RST = SIL_W'(30);
    localparam logic [CNT_W-1:0] MIN_SAMPLES_RST    = CNT_W'(8000);
    localparam logic [CNT_W-1:0] MAX_LEN_RST        = CNT_W'(160000);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_LEN      = 3'd0,
        REG_ENERGY_THR     = 3'd1,
        REG_SILENCE_FRAMES = 3'd2,
        REG_MIN_SAMPLES    = 3'd3,
        REG_MAX_LEN        = 3'd4
    } t_cfg_reg;

    typedef enum logic [CAUSE_W-1:0] {
        CAUSE_NONE    = 2'd0,
        CAUSE_SILENCE = 2'd1,
        CAUSE_MAX_LEN = 2'd2
    } t_end_cause;

    // Utterance end limits handed from the register block to the datapath.
    typedef struct packed {
        logic [SIL_W-1:0] silence_frames;
        logic [CNT_W-1:0] min_samples;
        logic [CNT_W-1:0] max_len;
    } t_cfg_lim;

endpackage

`default_nettype wire

### hw/rtl/evad_cfg.sv
// Configuration registers, effective frame length and the registered
// threshold-times-length product. Depends on evad_pkg.
`default_nettype none

module evad_cfg #(
    parameter int MAX_FRAME = evad_pkg::MAX_FRAME_DEF,
    parameter int LEN_EFF_W = $clog2(MAX_FRAME + 1),
    parameter int SUM_W     = evad_pkg::SQ_W + $clog2(MAX_FRAME)
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [evad_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [evad_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output logic      [LEN_EFF_W-1:0]             o_eff_len,
    output logic      [SUM_W-1:0]                 o_thr_len,
    output evad_pkg::t_cfg_lim                    o_lim
);

    logic [evad_pkg::LEN_W-1:0] r_frame_len;
    logic [evad_pkg::THR_W-1:0] r_energy_thr;
    logic [evad_pkg::SIL_W-1:0] r_silence_frames;
    logic [evad_pkg::CNT_W-1:0] r_min_samples;
    logic [evad_pkg::CNT_W-1:0] r_max_len;
    logic [SUM_W-1:0]           r_thr_len;
    logic [LEN_EFF_W-1:0]       w_eff_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_len      <= evad_pkg::FRAME_LEN_RST;
            r_energy_thr     <= evad_pkg::ENERGY_THR_RST;
            r_silence_frames <= evad_pkg::SILENCE_FRAMES_RST;
            r_min_samples    <= evad_pkg::MIN_SAMPLES_RST;
            r_max_len        <= evad_pkg::MAX_LEN_RST;
        end else if (i_cfg_we) begin
            case (evad_pkg::t_cfg_reg'(i_cfg_idx))
                evad_pkg::REG_FRAME_LEN: begin
                    r_frame_len <= i_cfg_data[evad_pkg::LEN_W-1:0];
                end
                evad_pkg::REG_ENERGY_THR: begin
                    r_energy_thr <= i_cfg_data[evad_pkg::THR_W-1:0];
                end
                evad_pkg::REG_SILENCE_FRAMES: begin
                    r_silence_frames <= i_cfg_data[evad_pkg::SIL_W-1:0];
                end
                evad_pkg::REG_MIN_SAMPLES: begin
                    r_min_samples <= i_cfg_data[evad_pkg::CNT_W-1:0];
                end
                evad_pkg::REG_MAX_LEN: begin
                    r_max_len <= i_cfg_data[evad_pkg::CNT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Clamp the frame length into 1..MAX_FRAME.
    always_comb begin
        if (r_frame_len == '0) begin
            w_eff_len = LEN_EFF_W'(1);
        end else if (32'(r_frame_len) > 32'(MAX_FRAME)) begin
            w_eff_len = LEN_EFF_W'(MAX_FRAME);
        end else begin
            w_eff_len = LEN_EFF_W'(r_frame_len);
        end
    end

    // Compare sum >= threshold * len instead of dividing the sum.
    always_ff @(posedge i_clk) begin
        r_thr_len <= SUM_W'(r_energy_thr) * SUM_W'(w_eff_len);
    end

    assign o_eff_len            = w_eff_len;
    assign o_thr_len            = r_thr_len;
    assign o_lim.silence_frames = r_silence_frames;
    assign o_lim.min_samples    = r_min_samples;
    assign o_lim.max_len        = r_max_len;

endmodule

`default_nettype wire

### hw/rtl/energy_vad_endpointer_core.sv
// Energy-based voice activity detector with utterance endpointer, top level.
// Depends on evad_pkg and evad_cfg.
//
//   channel  | handshake                    | payload
//   ---------+------------------------------+-------------------------------------------
//   in       | i_in_valid / o_in_stall      | i_sample
//   out      | o_out_valid / i_out_stall    | o_sample_out, o_frame_done, o_frame_speech,
//            |                              | o_utterance_last, o_end_cause
//   cfg      | i_cfg_we (no wait)           | i_cfg_idx, i_cfg_data
//
// One item per cycle sustained while the output is not stalled; an accepted item passes through
// the square register at the input and then the result register before its result is valid.
// The frame, silence and count state updates once per item as it moves into the result register.
// Synchronous active-low reset clears the counters and the valid flags and loads register defaults.
// The input stalls only while the input register is full and the result register is held.
`default_nettype none

module energy_vad_endpointer_core #(
    parameter int MAX_FRAME = evad_pkg::MAX_FRAME_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_stall,
    input  wire logic signed [evad_pkg::SAMPLE_W-1:0] i_sample,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output logic signed [evad_pkg::SAMPLE_W-1:0]     o_sample_out,
    output logic                                     o_frame_done,
    output logic                                     o_frame_speech,
    output logic                                     o_utterance_last,
    output logic [evad_pkg::CAUSE_W-1:0]             o_end_cause,
    input  wire logic                                i_cfg_we,
    input  wire logic [evad_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire logic [evad_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int LEN_EFF_W = $clog2(MAX_FRAME + 1);
    localparam int FP_W      = $clog2(MAX_FRAME);
    localparam int SUM_W     = evad_pkg::SQ_W + $clog2(MAX_FRAME);

    logic [LEN_EFF_W-1:0] w_eff_len;
    logic [SUM_W-1:0]     w_thr_len;
    evad_pkg::t_cfg_lim   w_lim;

    evad_cfg #(
        .MAX_FRAME (MAX_FRAME),
        .LEN_EFF_W (LEN_EFF_W),
        .SUM_W     (SUM_W)
    ) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_eff_len  (w_eff_len),
        .o_thr_len  (w_thr_len),
        .o_lim      (w_lim)
    );

    // Input register: sample and its square.
    logic                                r_s1_valid;
    logic signed [evad_pkg::SAMPLE_W-1:0] r_s1_sample;
    logic [evad_pkg::SQ_W-1:0]           r_s1_sq;
    logic signed [31:0]                  w_sq_full;

    // Running state.
    logic [SUM_W-1:0]           r_energy_sum;
    logic [FP_W-1:0]            r_frame_pos;
    logic [evad_pkg::SIL_W-1:0] r_silence_run;
    logic [evad_pkg::CNT_W-1:0] r_sample_count;
    logic [SUM_W-1:0]           n_energy_sum;
    logic [FP_W-1:0]            n_frame_pos;
    logic [evad_pkg::SIL_W-1:0] n_silence_run;
    logic [evad_pkg::CNT_W-1:0] n_sample_count;

    // Result register.
    logic                                r_out_valid;
    logic signed [evad_pkg::SAMPLE_W-1:0] r_out_sample;
    logic                                r_out_done;
    logic                                r_out_speech;
    logic                                r_out_last;
    evad_pkg::t_end_cause                r_out_cause;

    logic                       w_in_acc;
    logic                       w_move;
    logic [SUM_W-1:0]           w_sum;
    logic [LEN_EFF_W-1:0]       w_pos_inc;
    logic                       w_done;
    logic                       w_speech;
    logic [evad_pkg::SIL_W-1:0] w_sil_upd;
    logic [evad_pkg::CNT_W-1:0] w_cnt;
    evad_pkg::t_end_cause       w_cause;
    logic                       w_last;

    assign w_move     = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_s1_valid && !w_move;
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_sq_full  = i_sample * i_sample;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (w_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_s1_sample <= i_sample;
            r_s1_sq     <= w_sq_full[evad_pkg::SQ_W-1:0];
        end
    end

    always_comb begin
        w_sum     = r_energy_sum + SUM_W'(r_s1_sq);
        w_pos_inc = LEN_EFF_W'(r_frame_pos) + LEN_EFF_W'(1);
        w_done    = (w_pos_inc >= w_eff_len);
        w_speech  = w_done && (w_sum >= w_thr_len);
        w_cnt     = (r_sample_count != '1) ? r_sample_count + 1'b1 : r_sample_count;

        // Clear on speech, count up and saturate on a quiet frame.
        if (w_speech) begin
            w_sil_upd = '0;
        end else if (r_silence_run != '1) begin
            w_sil_upd = r_silence_run + 1'b1;
        end else begin
            w_sil_upd = r_silence_run;
        end

        // Silence wins when both end conditions hold.
        w_cause = evad_pkg::CAUSE_NONE;
        if (w_done) begin
            if (!w_speech && (w_sil_upd > w_lim.silence_frames)
                    && (w_cnt > w_lim.min_samples)) begin
                w_cause = evad_pkg::CAUSE_SILENCE;
            end else if (w_cnt >= w_lim.max_len) begin
                w_cause = evad_pkg::CAUSE_MAX_LEN;
            end
        end
        w_last = (w_cause != evad_pkg::CAUSE_NONE);

        n_energy_sum   = w_done ? '0 : w_sum;
        n_frame_pos    = w_done ? '0 : w_pos_inc[FP_W-1:0];
        n_silence_run  = !w_done ? r_silence_run : (w_last ? '0 : w_sil_upd);
        n_sample_count = w_last ? '0 : w_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_energy_sum   <= '0;
            r_frame_pos    <= '0;
            r_silence_run  <= '0;
            r_sample_count <= '0;
        end else if (w_move) begin
            r_energy_sum   <= n_energy_sum;
            r_frame_pos    <= n_frame_pos;
            r_silence_run  <= n_silence_run;
            r_sample_count <= n_sample_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_move) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_move) begin
            r_out_sample <= r_s1_sample;
            r_out_done   <= w_done;
            r_out_speech <= w_speech;
            r_out_last   <= w_last;
            r_out_cause  <= w_cause;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_sample_out     = r_out_sample;
    assign o_frame_done     = r_out_done;
    assign o_frame_speech   = r_out_speech;
    assign o_utterance_last = r_out_last;
    assign o_end_cause      = r_out_cause;

    // An utterance only ends on a frame boundary.
    a_last_on_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_utterance_last) |-> o_frame_done)
        else $error("utterance end without frame end");

    // A cause is reported exactly when the utterance ends.
    a_cause_with_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_end_cause != evad_pkg::CAUSE_NONE) == o_utterance_last))
        else $error("end cause and utterance end disagree");

    // Closing a frame leaves an empty frame behind.
    a_frame_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_move && w_done) |=> (r_energy_sum == '0 && r_frame_pos == '0))
        else $error("frame state not cleared at frame end");

    // Ending an utterance restarts the sample count and the silence run.
    a_utt_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_move && w_last) |=> (r_sample_count == '0 && r_silence_run == '0))
        else $error("utterance state not cleared at utterance end");

endmodule

`default_nettype wire
